FILE: src/tlts_pkg.sv
// shared types, token codes and character tables for the token scanner
// no dependencies
`default_nettype none

package tlts_pkg;

    // defaults for the top-level parameters
    localparam int MAX_WORD_LENGTH_DEF = 255;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam int NUM_SPECIALS = 10;
    localparam int NUM_KEYWORDS = 8;
    localparam int KW_SLOTS     = 8;

    // token kinds
    localparam logic [4:0] KIND_ASSIGN   = 5'd10;
    localparam logic [4:0] KIND_KEYWORD0 = 5'd11;
    localparam logic [4:0] KIND_NUMBER   = 5'd19;
    localparam logic [4:0] KIND_IDENT    = 5'd20;
    localparam logic [4:0] KIND_ERROR    = 5'd21;

    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_EQUALS = 8'h3D;

    // single-character tokens, position gives the token kind
    localparam logic [7:0] SPECIAL_CHARS [NUM_SPECIALS] = '{
        8'h3B,  // ;
        8'h3D,  // =
        8'h3C,  // <
        8'h28,  // (
        8'h29,  // )
        8'h2F,  // /
        8'h2A,  // *
        8'h2B,  // +
        8'h2D,  // -
        8'h20   // space
    };

    // keyword spellings, zero padded
    localparam logic [7:0] KW_TEXT [NUM_KEYWORDS][KW_SLOTS] = '{
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "h", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "p", "e", "a", "t", 8'h00, 8'h00},
        '{"u", "n", "t", "i", "l", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "a", "d", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "r", "i", "t", "e", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd4, 3'd5
    };

    // results of one input item: an optional word token, then an optional
    // single-character or assign token
    typedef struct packed {
        logic       has_word;
        logic [4:0] word_kind;
        logic [7:0] word_len;
        logic       has_tok;
        logic [4:0] tok_kind;
        logic [7:0] tok_char;
    } step_rec_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

endpackage

`default_nettype wire

FILE: src/tlts_if.sv
// valid/ready channel interfaces for source characters and tokens
// no dependencies
`default_nettype none

interface tlts_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       line_end;

    modport source (output valid, output ch, output line_end, input ready);
    modport sink   (input valid, input ch, input line_end, output ready);
endinterface

interface tlts_token_if;
    logic       valid;
    logic       ready;
    logic [4:0] token_kind;
    logic [7:0] token_char;
    logic [7:0] word_length;
    logic       last_of_run;

    modport source (output valid, output token_kind, output token_char,
                    output word_length, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_char,
                    input word_length, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: src/tiny_language_token_scanner.sv
// token scanner top level; depends on tlts_pkg, tlts_if, tlts_front, tlts_queue, tlts_back
// a token's record enters the queue when its character is accepted and then loads the
// output register once that register is empty or its token is taken
// throughput: one character per cycle while each gives at most one token; a two-token
// character yields both tokens in turn; intake stops while the queue is full
// reset: asynchronous, clears the word state, any held colon, the queue and the output
`default_nettype none

module tiny_language_token_scanner #(
    parameter int MAX_WORD_LENGTH = tlts_pkg::MAX_WORD_LENGTH_DEF,
    parameter int QUEUE_DEPTH     = tlts_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tlts_char_if.sink     chars,
    tlts_token_if.source  tokens
);

    // records from the front end, one per character that gives any token
    tlts_pkg::step_rec_t push_rec;
    tlts_pkg::step_rec_t head;
    logic                push;
    logic                full;
    logic                pop;
    logic                empty;

    // front end: word state, colon lookahead and classification
    tlts_front #(
        .MAX_WORD_LENGTH (MAX_WORD_LENGTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .rec        (push_rec),
        .rec_push   (push),
        .queue_full (full)
    );

    // decouples character intake from token delivery
    tlts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    // back end: word token first, then the single-character or assign token
    tlts_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .tokens (tokens)
    );

endmodule

`default_nettype wire

FILE: src/tlts_front.sv
// front end: accepts characters, keeps the word state and classifies words
// depends on tlts_pkg and tlts_if
`default_nettype none

module tlts_front #(
    parameter int MAX_WORD_LENGTH = tlts_pkg::MAX_WORD_LENGTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    tlts_char_if.sink              chars,
    output tlts_pkg::step_rec_t    rec,
    output logic                   rec_push,
    input  wire logic              queue_full
);

    localparam int CNT_W = $clog2(MAX_WORD_LENGTH + 1);

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             only_digits;
        logic             only_letters;
        logic             saw_foreign;
        logic [7:0]       hits;
    } word_t;

    typedef struct packed {
        logic       has;
        logic [4:0] kind;
        logic [7:0] len;
    } wtok_t;

    localparam word_t WORD_CLEAR = '{
        cnt: '0, only_digits: 1'b1, only_letters: 1'b1, saw_foreign: 1'b0, hits: 8'hFF
    };

    word_t word_reg, word_next;
    logic  colon_reg, colon_next;

    function automatic word_t append(input word_t w, input logic [7:0] c);
        word_t r;
        logic  dig;
        logic  is_let;
        r      = w;
        dig    = tlts_pkg::is_digit(c);
        is_let = tlts_pkg::is_letter(c);
        for (int k = 0; k < tlts_pkg::NUM_KEYWORDS; k++)
        begin
            if (!((w.cnt < CNT_W'(tlts_pkg::KW_LEN[k])) &&
                  (tlts_pkg::KW_TEXT[k][w.cnt[2:0]] == c)))
            begin
                r.hits[k] = 1'b0;
            end
        end
        if (!dig)
        begin
            r.only_digits = 1'b0;
        end
        if (!is_let)
        begin
            r.only_letters = 1'b0;
        end
        if (!dig && !is_let)
        begin
            r.saw_foreign = 1'b1;
        end
        if (32'(w.cnt) < 32'(MAX_WORD_LENGTH))
        begin
            r.cnt = w.cnt + 1'b1;
        end
        return r;
    endfunction

    // later assignments take priority: keywords, then number, ident, error
    function automatic wtok_t classify(input word_t w);
        wtok_t t;
        t.has  = 1'b0;
        t.kind = tlts_pkg::KIND_ERROR;
        t.len  = (32'(w.cnt) > 32'd255) ? 8'hFF : 8'(w.cnt);
        if (w.saw_foreign)
        begin
            t.has  = 1'b1;
            t.kind = tlts_pkg::KIND_ERROR;
        end
        if (w.only_letters)
        begin
            t.has  = 1'b1;
            t.kind = tlts_pkg::KIND_IDENT;
        end
        if (w.only_digits)
        begin
            t.has  = 1'b1;
            t.kind = tlts_pkg::KIND_NUMBER;
        end
        for (int k = tlts_pkg::NUM_KEYWORDS - 1; k >= 0; k--)
        begin
            if (w.hits[k] && (w.cnt == CNT_W'(tlts_pkg::KW_LEN[k])))
            begin
                t.has  = 1'b1;
                t.kind = tlts_pkg::KIND_KEYWORD0 + 5'(k);
            end
        end
        if (w.cnt == '0)
        begin
            t.has = 1'b0;
        end
        return t;
    endfunction

    logic       accept;
    logic       spec_hit;
    logic [4:0] spec_kind;
    word_t      pre_word;
    word_t      post_word;
    wtok_t      wtok;

    assign chars.ready = !queue_full;
    assign accept      = chars.valid && chars.ready;
    assign rec_push    = accept && (rec.has_word || rec.has_tok);

    always_comb
    begin
        spec_hit  = 1'b0;
        spec_kind = '0;
        for (int i = 0; i < tlts_pkg::NUM_SPECIALS; i++)
        begin
            if (chars.ch == tlts_pkg::SPECIAL_CHARS[i])
            begin
                spec_hit  = 1'b1;
                spec_kind = 5'(i);
            end
        end
    end

    always_comb
    begin
        // a held colon not followed by '=' joins the word first
        pre_word   = colon_reg ? append(word_reg, tlts_pkg::CHAR_COLON) : word_reg;
        post_word  = append(pre_word, chars.ch);
        rec        = '0;
        word_next  = word_reg;
        colon_next = 1'b0;
        wtok       = classify(pre_word);
        if (colon_reg && (chars.ch == tlts_pkg::CHAR_EQUALS))
        begin
            wtok          = classify(word_reg);
            rec.has_word  = wtok.has;
            rec.word_kind = wtok.kind;
            rec.word_len  = wtok.len;
            rec.has_tok   = 1'b1;
            rec.tok_kind  = tlts_pkg::KIND_ASSIGN;
            word_next     = WORD_CLEAR;
        end
        else if (spec_hit)
        begin
            rec.has_word  = wtok.has;
            rec.word_kind = wtok.kind;
            rec.word_len  = wtok.len;
            rec.has_tok   = 1'b1;
            rec.tok_kind  = spec_kind;
            rec.tok_char  = chars.ch;
            word_next     = WORD_CLEAR;
        end
        else if ((chars.ch == tlts_pkg::CHAR_COLON) && !chars.line_end)
        begin
            word_next  = pre_word;
            colon_next = 1'b1;
        end
        else if (chars.line_end)
        begin
            wtok          = classify(post_word);
            rec.has_word  = wtok.has;
            rec.word_kind = wtok.kind;
            rec.word_len  = wtok.len;
            word_next     = WORD_CLEAR;
        end
        else
        begin
            word_next = post_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= WORD_CLEAR;
            colon_reg <= 1'b0;
        end
        else if (accept)
        begin
            word_reg  <= word_next;
            colon_reg <= colon_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/tlts_queue.sv
// short queue of per-item token records between front and back end
// depends on tlts_pkg
`default_nettype none

module tlts_queue #(
    parameter int DEPTH = tlts_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire tlts_pkg::step_rec_t  push_rec,
    output logic                      full,
    input  wire logic                 pop,
    output tlts_pkg::step_rec_t       head,
    output logic                      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tlts_pkg::step_rec_t slots_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic                do_push, do_pop;

    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/tlts_back.sv
// back end: splits each record into its tokens and drives the output register
// depends on tlts_pkg and tlts_if
`default_nettype none

module tlts_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tlts_pkg::step_rec_t  head,
    input  wire logic                 empty,
    output logic                      pop,
    tlts_token_if.source              tokens
);

    logic       valid_reg;
    logic       word_done_reg, word_done_next;
    logic [4:0] kind_reg, kind_next;
    logic [7:0] char_reg, char_next;
    logic [7:0] len_reg, len_next;
    logic       last_reg, last_next;
    logic       load;

    assign load = !empty && (!valid_reg || tokens.ready);

    always_comb
    begin
        pop            = 1'b0;
        word_done_next = word_done_reg;
        kind_next      = head.tok_kind;
        char_next      = head.tok_char;
        len_next       = '0;
        last_next      = 1'b1;
        if (load)
        begin
            if (head.has_word && !word_done_reg)
            begin
                kind_next = head.word_kind;
                char_next = '0;
                len_next  = head.word_len;
                last_next = !head.has_tok;
                if (head.has_tok)
                begin
                    word_done_next = 1'b1;
                end
                else
                begin
                    pop = 1'b1;
                end
            end
            else
            begin
                pop            = 1'b1;
                word_done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind_next;
            char_reg <= char_next;
            len_reg  <= len_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            word_done_reg <= 1'b0;
        end
        else
        begin
            word_done_reg <= word_done_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (tokens.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign tokens.valid       = valid_reg;
    assign tokens.token_kind  = kind_reg;
    assign tokens.token_char  = char_reg;
    assign tokens.word_length = len_reg;
    assign tokens.last_of_run = last_reg;

endmodule

`default_nettype wire

FILE: verif/tb_tiny_language_token_scanner.sv
`timescale 1ns / 100ps
// self-checking testbench for tiny_language_token_scanner: drives source lines,
// predicts the token stream and compares every token field by field
// depends on tlts_pkg, tlts_if and the scanner rtl

module tb_tiny_language_token_scanner;

    // word length saturates here with the default parameter
    localparam int WORD_CAP     = tlts_pkg::MAX_WORD_LENGTH_DEF;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_AT      = 150;   // token count at which the sink holds off
    localparam int LONG_HOLD    = 300;   // cycles of that hold
    localparam int DRAIN_CYCLES = 20;
    localparam int NO_TOKEN     = -1;

    // single-character token kinds, in code order
    typedef enum logic [4:0] {
        TOK_SEMI, TOK_EQUAL, TOK_LESS, TOK_LPAREN, TOK_RPAREN,
        TOK_SLASH, TOK_STAR, TOK_PLUS, TOK_MINUS, TOK_SPACE
    } single_kind_e;

    // keyword spellings right-aligned, zero padded, in code order
    localparam logic [8*6-1:0] KW_SPELL [tlts_pkg::NUM_KEYWORDS] = '{
        "if", "then", "else", "end", "repeat", "until", "read", "write"
    };
    localparam int KW_SIZE [tlts_pkg::NUM_KEYWORDS] = '{2, 4, 4, 3, 6, 5, 4, 5};

    localparam logic [8*10-1:0] SPECIAL_TEXT = ";=<()/*+- ";

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } char_item_t;

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] chr;
        logic [7:0] len;
        logic       last;
    } token_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tlts_char_if  chars_if ();
    tlts_token_if tokens_if ();

    tiny_language_token_scanner i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .tokens (tokens_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // scanner prediction state, mirrors the word being gathered
    // ---------------------------------------------------------------
    int         sc_len     = 0;
    bit         sc_digits  = 1'b1;
    bit         sc_letters = 1'b1;
    bit         sc_foreign = 1'b0;
    logic [7:0] sc_kw      = 8'hFF;
    bit         sc_colon   = 1'b0;

    token_t     step_tokens [$];   // tokens caused by the character in hand
    token_t     tokens_due  [$];   // predicted tokens not yet seen at the output
    int         errors = 0;

    function automatic logic [7:0] kw_char(input int k, input int p);
        return KW_SPELL[k][8*(KW_SIZE[k]-1-p) +: 8];
    endfunction

    function automatic int single_kind(input logic [7:0] c);
        case (c)
            ";":     return TOK_SEMI;
            "=":     return TOK_EQUAL;
            "<":     return TOK_LESS;
            "(":     return TOK_LPAREN;
            ")":     return TOK_RPAREN;
            "/":     return TOK_SLASH;
            "*":     return TOK_STAR;
            "+":     return TOK_PLUS;
            "-":     return TOK_MINUS;
            " ":     return TOK_SPACE;
            default: return NO_TOKEN;
        endcase
    endfunction

    // add one character to the word; keyword tracking sees every character
    task automatic add_to_word(input logic [7:0] c);
        logic is_num;
        logic is_alpha;
        int   k;
        is_num   = (c >= "0") && (c <= "9");
        is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        for (k = 0; k < tlts_pkg::NUM_KEYWORDS; k++)
            if (sc_len >= KW_SIZE[k] || kw_char(k, sc_len) != c)
                sc_kw[k] = 1'b0;
        if (!is_num)
            sc_digits = 1'b0;
        if (!is_alpha)
            sc_letters = 1'b0;
        if (!is_num && !is_alpha)
            sc_foreign = 1'b1;
        if (sc_len < WORD_CAP)
            sc_len++;
    endtask

    // end the word: keyword first, then number, identifier, error;
    // an empty word or one mixing only letters and digits gives nothing
    task automatic close_word();
        int kind;
        int k;
        kind = NO_TOKEN;
        if (sc_len != 0)
        begin
            for (k = 0; k < tlts_pkg::NUM_KEYWORDS; k++)
                if (kind == NO_TOKEN && sc_kw[k] && sc_len == KW_SIZE[k])
                    kind = tlts_pkg::KIND_KEYWORD0 + k;
            if (kind == NO_TOKEN && sc_digits)
                kind = tlts_pkg::KIND_NUMBER;
            if (kind == NO_TOKEN && sc_letters)
                kind = tlts_pkg::KIND_IDENT;
            if (kind == NO_TOKEN && sc_foreign)
                kind = tlts_pkg::KIND_ERROR;
        end
        if (kind != NO_TOKEN)
            step_tokens.insert(step_tokens.size(),
                               token_t'{5'(kind), 8'h00, 8'(sc_len), 1'b0});
        sc_len     = 0;
        sc_digits  = 1'b1;
        sc_letters = 1'b1;
        sc_foreign = 1'b0;
        sc_kw      = 8'hFF;
    endtask

    // predict the tokens of one accepted character item
    task automatic scan_char(input logic [7:0] c, input logic eol);
        int     kind;
        token_t t;
        step_tokens.delete();
        kind = single_kind(c);
        if (sc_colon && c == tlts_pkg::CHAR_EQUALS)
        begin
            // assign: the word so far goes out first
            sc_colon = 1'b0;
            close_word();
            step_tokens.insert(step_tokens.size(),
                               token_t'{tlts_pkg::KIND_ASSIGN, 8'h00, 8'h00, 1'b0});
        end
        else
        begin
            // a held colon with no '=' after it is just a word character
            if (sc_colon)
            begin
                sc_colon = 1'b0;
                add_to_word(tlts_pkg::CHAR_COLON);
            end
            if (kind != NO_TOKEN)
            begin
                close_word();
                step_tokens.insert(step_tokens.size(), token_t'{5'(kind), c, 8'h00, 1'b0});
            end
            else if (c == tlts_pkg::CHAR_COLON && !eol)
                sc_colon = 1'b1;
            else
            begin
                // includes a colon at the end of a line, which joins at once
                add_to_word(c);
                if (eol)
                    close_word();
            end
        end
        foreach (step_tokens[i])
        begin
            t      = step_tokens[i];
            t.last = (i == step_tokens.size() - 1);
            tokens_due.insert(tokens_due.size(), t);
        end
    endtask

    // ---------------------------------------------------------------
    // idle pattern: stretches of calm (no waits) and of random waits
    // ---------------------------------------------------------------
    function automatic int pick_wait(inout int left, inout bit calm);
        if (left == 0)
        begin
            left = $urandom_range(10, 60);
            calm = ($urandom_range(0, 3) == 0);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    // ---------------------------------------------------------------
    // stimulus building: lines are gathered, then queued with line_end
    // set on their final character
    // ---------------------------------------------------------------
    char_item_t pending   [$];
    logic [7:0] line_text [$];

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_text.insert(line_text.size(), s[i]);
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_text.size(); i++)
            pending.insert(pending.size(),
                           char_item_t'{line_text[i], i == line_text.size() - 1});
        line_text.delete();
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    // one lexeme of the language, mostly well formed, some noise
    task automatic random_lexeme();
        int         pick;
        int         n;
        int         k;
        int         i;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            // keyword, sometimes spoilt by case, truncation or an extra letter
            k = $urandom_range(0, tlts_pkg::NUM_KEYWORDS - 1);
            n = $urandom_range(0, 11);
            for (i = 0; i < KW_SIZE[k]; i++)
            begin
                b = kw_char(k, i);
                if (n == 0 && i == 0)
                    b = b - 8'h20;
                if (!(n == 1 && i == KW_SIZE[k] - 1))
                    line_text.insert(line_text.size(), b);
            end
            if (n == 2)
                line_text.insert(line_text.size(), rand_letter());
        end
        else if (pick < 45)
        begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
                line_text.insert(line_text.size(), rand_letter());
        end
        else if (pick < 55)
        begin
            n = $urandom_range(1, 5);
            for (i = 0; i < n; i++)
                line_text.insert(line_text.size(), 8'("0" + $urandom_range(0, 9)));
        end
        else if (pick < 70)
            line_text.insert(line_text.size(), SPECIAL_TEXT[8*$urandom_range(0, 9) +: 8]);
        else if (pick < 78)
            add_text(":=");
        else if (pick < 85)
        begin
            // letters and digits mixed, no token expected when both kinds occur
            n = $urandom_range(2, 6);
            for (i = 0; i < n; i++)
                line_text.insert(line_text.size(),
                                 $urandom_range(0, 1) ? rand_letter()
                                                      : 8'("0" + $urandom_range(0, 9)));
        end
        else if (pick < 92)
        begin
            n = $urandom_range(1, 5);
            for (i = 0; i < n; i++)
                line_text.insert(line_text.size(),
                                 $urandom_range(0, 1) ? rand_letter()
                                                      : 8'($urandom_range(0, 255)));
        end
        else if (pick < 97)
            line_text.insert(line_text.size(), tlts_pkg::CHAR_COLON);
        else
            line_text.insert(line_text.size(), 8'($urandom_range(0, 255)));
    endtask

    // ---------------------------------------------------------------
    // character driver: offers the pending items, predicts on acceptance
    // ---------------------------------------------------------------
    char_item_t staged_item;
    bit         staged     = 1'b0;
    int         staged_gap = 0;
    int         src_left   = 0;
    bit         src_calm   = 1'b0;

    always @(posedge clk)
    begin : char_driver
        logic took;
        took = chars_if.valid && chars_if.ready;
        if (rst_n)
        begin
            if (took)
                scan_char(chars_if.ch, chars_if.line_end);
            // a new item may go out only once the channel is free
            if (!chars_if.valid || took)
            begin
                if (!staged && pending.size() != 0)
                begin
                    staged_item = pending.pop_front();
                    staged_gap  = pick_wait(src_left, src_calm);
                    staged      = 1'b1;
                end
                if (staged && staged_gap == 0)
                begin
                    chars_if.valid    <= 1'b1;
                    chars_if.ch       <= staged_item.ch;
                    chars_if.line_end <= staged_item.line_end;
                    staged = 1'b0;
                end
                else
                begin
                    chars_if.valid <= 1'b0;
                    if (staged)
                        staged_gap--;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // token monitor: checks each accepted token against the oldest
    // prediction and paces ready, with one long hold-off to fill the block
    // ---------------------------------------------------------------
    int     sink_wait   = 0;
    int     sink_left   = 0;
    bit     sink_calm   = 1'b0;
    int     tokens_seen = 0;

    always @(posedge clk)
    begin : token_monitor
        token_t want;
        if (rst_n)
        begin
            if (tokens_if.valid && tokens_if.ready)
            begin
                if (tokens_due.size() == 0)
                begin
                    $display("%0t: token expected none actual kind %0d char %0d len %0d last %0d",
                             $time, tokens_if.token_kind, tokens_if.token_char,
                             tokens_if.word_length, tokens_if.last_of_run);
                    errors++;
                end
                else
                begin
                    want = tokens_due.pop_front();
                    if (tokens_if.token_kind !== want.kind)
                    begin
                        $display("%0t: token_kind expected %0d actual %0d",
                                 $time, want.kind, tokens_if.token_kind);
                        errors++;
                    end
                    if (tokens_if.token_char !== want.chr)
                    begin
                        $display("%0t: token_char expected %0d actual %0d",
                                 $time, want.chr, tokens_if.token_char);
                        errors++;
                    end
                    if (tokens_if.word_length !== want.len)
                    begin
                        $display("%0t: word_length expected %0d actual %0d",
                                 $time, want.len, tokens_if.word_length);
                        errors++;
                    end
                    if (tokens_if.last_of_run !== want.last)
                    begin
                        $display("%0t: last_of_run expected %0d actual %0d",
                                 $time, want.last, tokens_if.last_of_run);
                        errors++;
                    end
                end
                tokens_seen++;
                sink_wait = (tokens_seen == HOLD_AT) ? LONG_HOLD
                                                     : pick_wait(sink_left, sink_calm);
            end
            else if (sink_wait > 0)
                sink_wait--;
            tokens_if.ready <= (sink_wait == 0);
        end
    end

    // ---------------------------------------------------------------
    // sequence: build stimulus, reset, run, drain, verdict
    // ---------------------------------------------------------------
    initial
    begin : main_seq
        int  total;
        int  n;
        int  i;
        bit  long_done;
        chars_if.valid    = 1'b0;
        chars_if.ch       = 8'h00;
        chars_if.line_end = 1'b0;
        tokens_if.ready   = 1'b0;

        // directed lines
        add_text("a:=1;");           // word flushed before assign
        send_line();
        add_text(":x:");             // lone colon, colon ending a line
        send_line();
        line_text.insert(line_text.size(), 8'h00);  // byte extremes form an error word
        line_text.insert(line_text.size(), 8'hFF);
        add_text("<");
        send_line();
        add_text("end()/*+- =");     // keyword, then every single-character token but ';' and '<'
        send_line();
        add_text(":=");              // assign with no word before it
        send_line();

        // random lines, with one word long enough to saturate its length
        total     = pending.size() + RANDOM_ITEMS;
        long_done = 1'b0;
        while (pending.size() < total)
        begin
            if (!long_done && pending.size() > 400)
            begin
                n = $urandom_range(WORD_CAP + 1, WORD_CAP + 15);
                for (i = 0; i < n; i++)
                    line_text.insert(line_text.size(), rand_letter());
                add_text(";");
                send_line();
                long_done = 1'b1;
            end
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
            begin
                random_lexeme();
                if (i < n - 1 && $urandom_range(0, 1))
                    add_text(" ");
            end
            send_line();
        end

        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // all items accepted, then all predictions met, then a short drain
        while (pending.size() != 0 || staged || chars_if.valid)
            @(negedge clk);
        while (tokens_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("tiny_language_token_scanner: match");
        else
            $display("tiny_language_token_scanner: mismatch");
        $finish;
    end

    // run limit, several times the slowest correct run
    initial
    begin : watchdog
        #4000000;
        $display("tiny_language_token_scanner: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
src/tlts_pkg.sv
src/tlts_if.sv
src/tlts_front.sv
src/tlts_queue.sv
src/tlts_back.sv
src/tiny_language_token_scanner.sv
verif/tb_tiny_language_token_scanner.sv
